// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; take in with a plain include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion sampled on clk, switched off while rst_n is low
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// concurrent assertion sampled on clk, checked during reset as well
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed during or after reset");

`endif

// ===== rtl/cpf_pkg.sv =====
// shared constants and types for the cart position fusion block
// no dependencies; imported by the top level
package cpf_pkg;

    // field widths
    localparam int ElapsedW  = 20;
    localparam int StepW     = 32;
    localparam int DistW     = 12;
    localparam int PosW      = 32;
    localparam int CountW    = 22;
    localparam int FramesW   = 8;
    localparam int GainW     = 17;
    localparam int MmW       = 16;
    localparam int ScaleW    = 3;
    localparam int ScaledW   = DistW + ScaleW;
    localparam int CfgDataW  = 20;
    localparam int CfgIdxW   = 3;
    localparam int InDataW   = 64;
    localparam int ErrW      = PosW + 2;
    localparam int ProdW     = ErrW + GainW + 1;

    typedef logic [CfgIdxW-1:0] cfg_idx_t;

    // register indexes
    localparam cfg_idx_t REG_POLL_PERIOD    = 3'd0;
    localparam cfg_idx_t REG_STARTUP_FRAMES = 3'd1;
    localparam cfg_idx_t REG_TRUST_MOVING   = 3'd2;
    localparam cfg_idx_t REG_TRUST_STILL    = 3'd3;
    localparam cfg_idx_t REG_MM_PER_STEP    = 3'd4;
    localparam cfg_idx_t REG_DIST_SCALE     = 3'd5;

    // register reset values
    localparam logic [ElapsedW-1:0] POLL_PERIOD_RST    = 20'd30000;
    localparam logic [FramesW-1:0]  STARTUP_FRAMES_RST = 8'd30;
    localparam logic [GainW-1:0]    TRUST_MOVING_RST   = 17'd1638;
    localparam logic [GainW-1:0]    TRUST_STILL_RST    = 17'd82;
    localparam logic [MmW-1:0]      MM_PER_STEP_RST    = 16'd6554;
    localparam logic [ScaleW-1:0]   DIST_SCALE_RST     = 3'd2;

    // unity gain in Q1.16
    localparam logic [GainW-1:0] GAIN_ONE = 17'd65536;

endpackage

// ===== rtl/cart_position_fusion.sv =====
// cart position fusion: step-count prediction blended with a distance sensor
// depends on cpf_pkg
//
// Usage:
//   s_ channel: one tick per transfer. s_tdata holds elapsed_us [19:0],
//   step_count [51:20] and sensor_distance [63:52]; s_tuser is cart_moving.
//   m_ channel: one result per tick. m_tdata is position_mm (signed Q16.16),
//   m_tuser is sensor_used.
//   cfg channel: register writes by index, always ready; write only while
//   no tick is in flight.
// Pipeline: the tick lands in the input register at the transfer, then
//   passes the step product / poll stage and the blend and output register
//   before m_tvalid rises.
// Throughput: one tick per cycle while m_tready is high; the position
//   recurrence closes through the blend multiplier in the output stage.
// Reset (aresetn low at a clock edge): registers return to their defaults,
//   the estimate, step history and poll timer clear, so the first tick polls.
// Stall: with m_tready low the three stages fill; s_tready drops only when
//   all of them hold a tick, and m_tdata/m_tuser stay put until the transfer.
module cart_position_fusion (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input ticks
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cpf_pkg::InDataW-1:0]   s_tdata,  // elapsed_us, step_count, sensor_distance
    input  logic                          s_tuser,  // cart_moving
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cpf_pkg::PosW-1:0]      m_tdata,  // position_mm
    output logic                          m_tuser,  // sensor_used
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  cpf_pkg::cfg_idx_t             cfg_index,
    input  logic [cpf_pkg::CfgDataW-1:0]  cfg_data
);
    import cpf_pkg::*;

    // configuration registers
    logic [ElapsedW-1:0] poll_period_reg;
    logic [GainW-1:0]    trust_moving_reg;
    logic [GainW-1:0]    trust_still_reg;
    logic [MmW-1:0]      mm_per_step_reg;
    logic [ScaleW-1:0]   dist_scale_reg;

    // filter state
    logic [StepW-1:0]          prev_steps_reg;
    logic signed [CountW-1:0]  countdown_reg;
    logic signed [CountW-1:0]  countdown_next;
    logic [FramesW-1:0]        startup_left_reg;

    // stage 0: input register
    logic                s0_valid_reg;
    logic [ElapsedW-1:0] s0_elapsed_reg;
    logic [StepW-1:0]    s0_delta_reg;
    logic                s0_moving_reg;
    logic [DistW-1:0]    s0_dist_reg;

    // stage 1: step product and poll decision
    logic                s1_valid_reg;
    logic [PosW-1:0]     s1_step_prod_reg;
    logic [PosW-1:0]     s1_step_prod_next;
    logic [ScaledW-1:0]  s1_scaled_reg;
    logic [GainW-1:0]    s1_gain_reg;
    logic [GainW-1:0]    s1_gain_next;
    logic                s1_used_reg;
    logic                s1_used_next;

    // stage 2: blend and output register
    logic                out_valid_reg;
    logic [PosW-1:0]     pos_reg;
    logic [PosW-1:0]     pos_next;
    logic                out_used_reg;

    logic                in_xfer;
    logic                adv0;
    logic                adv1;
    logic                cfg_xfer;

    // handshake chain
    assign adv1      = s1_valid_reg && (!out_valid_reg || m_tready);
    assign adv0      = s0_valid_reg && (!s1_valid_reg || adv1);
    assign s_tready  = !s0_valid_reg || adv0;
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = pos_reg;
    assign m_tuser  = out_used_reg;

    // configuration register writes; startup frames go straight to the counter below
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poll_period_reg    <= POLL_PERIOD_RST;
            trust_moving_reg   <= TRUST_MOVING_RST;
            trust_still_reg    <= TRUST_STILL_RST;
            mm_per_step_reg    <= MM_PER_STEP_RST;
            dist_scale_reg     <= DIST_SCALE_RST;
        end else if (cfg_xfer) begin
            case (cfg_index)
                REG_POLL_PERIOD:    poll_period_reg    <= cfg_data;
                REG_TRUST_MOVING:   trust_moving_reg   <= cfg_data[GainW-1:0];
                REG_TRUST_STILL:    trust_still_reg    <= cfg_data[GainW-1:0];
                REG_MM_PER_STEP:    mm_per_step_reg    <= cfg_data[MmW-1:0];
                REG_DIST_SCALE:     dist_scale_reg     <= cfg_data[ScaleW-1:0];
                default: ;
            endcase
        end
    end

    // stage 0: capture the tick and form the step delta
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg   <= 1'b0;
            prev_steps_reg <= '0;
        end else begin
            if (in_xfer) begin
                s0_valid_reg   <= 1'b1;
                prev_steps_reg <= s_tdata[51:20];
            end else if (adv0) begin
                s0_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            s0_elapsed_reg <= s_tdata[19:0];
            s0_delta_reg   <= s_tdata[51:20] - prev_steps_reg;
            s0_moving_reg  <= s_tuser;
            s0_dist_reg    <= s_tdata[63:52];
        end
    end

    // stage 1 next values: step product, poll timer and gain choice
    always_comb begin
        s1_step_prod_next = s0_delta_reg * {{(PosW-MmW){1'b0}}, mm_per_step_reg};
        countdown_next    = countdown_reg - $signed({2'b00, s0_elapsed_reg});
        s1_used_next      = (countdown_next <= $signed(22'd0)) || (startup_left_reg != '0);
        if (startup_left_reg != '0) begin
            s1_gain_next = GAIN_ONE;
        end else if (s0_moving_reg) begin
            s1_gain_next = (trust_moving_reg > GAIN_ONE) ? GAIN_ONE : trust_moving_reg;
        end else begin
            s1_gain_next = (trust_still_reg > GAIN_ONE) ? GAIN_ONE : trust_still_reg;
        end
    end

    // stage 1 control state: poll timer and startup frames
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg     <= 1'b0;
            countdown_reg    <= '0;
            startup_left_reg <= STARTUP_FRAMES_RST;
        end else begin
            if (adv0) begin
                s1_valid_reg <= 1'b1;
            end else if (adv1) begin
                s1_valid_reg <= 1'b0;
            end
            if (cfg_xfer && cfg_index == REG_STARTUP_FRAMES) begin
                startup_left_reg <= cfg_data[FramesW-1:0];
            end else if (adv0 && s1_used_next && startup_left_reg != '0) begin
                startup_left_reg <= startup_left_reg - 8'd1;
            end
            if (adv0) begin
                countdown_reg <= s1_used_next ? $signed({2'b00, poll_period_reg})
                                              : countdown_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv0) begin
            s1_step_prod_reg <= s1_step_prod_next;
            s1_scaled_reg    <= s0_dist_reg * {{(ScaledW-ScaleW){1'b0}}, dist_scale_reg};
            s1_gain_reg      <= s1_gain_next;
            s1_used_reg      <= s1_used_next;
        end
    end

    // stage 2: predict, then blend toward the scaled sensor distance when the sensor is used
    logic [PosW-1:0]          pos_pred;
    logic signed [ErrW-1:0]   blend_err;
    logic signed [GainW:0]    blend_gain;
    logic signed [ProdW-1:0]  blend_prod;
    logic signed [ProdW-1:0]  blend_round;

    always_comb begin
        pos_pred    = pos_reg + s1_step_prod_reg;
        blend_err   = $signed({{(ErrW-ScaledW-16){1'b0}}, s1_scaled_reg, 16'd0})
                    - $signed({{(ErrW-PosW){pos_pred[PosW-1]}}, pos_pred});
        blend_gain  = $signed({1'b0, s1_gain_reg});
        blend_prod  = blend_err * blend_gain;
        blend_round = blend_prod + $signed(52'd32768);
        pos_next    = s1_used_reg ? pos_pred + blend_round[47:16] : pos_pred;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end else begin
            if (adv1) begin
                out_valid_reg <= 1'b1;
                pos_reg       <= pos_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            out_used_reg <= s1_used_reg;
        end
    end

endmodule

// ===== rtl/cpf_checker.sv =====
// port-level checks for the cart position fusion block
// depends on assert_macros.svh; bound to cart_position_fusion below
`include "assert_macros.svh"

module cpf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        cfg_ready
);

    // a stalled result stays offered
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)

    // a stalled result keeps its payload
    `ASSERT_CLK(a_out_stable, aclk, aresetn,
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))

    // input back-pressure only while a result waits at the output
    `ASSERT_CLK(a_in_stall, aclk, aresetn, !s_tready |-> m_tvalid && !m_tready)

    // reset empties the output and keeps the config channel open
    `ASSERT_CLK_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid && cfg_ready)

endmodule

bind cart_position_fusion cpf_checker u_cpf_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_ready (cfg_ready)
);
